// ===== sv/blw_pkg.sv =====
// ----------------------------------------------------------------------------
// blw_pkg
// Shared types and constants for the line-of-sight walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blw_pkg;

  localparam int unsigned CoordBits = 8;
  localparam int unsigned FeatBits  = 8;
  localparam int unsigned ErrBits   = CoordBits + 1;

  typedef logic [CoordBits-1:0]      coord_t;
  typedef logic [FeatBits-1:0]       feat_t;
  typedef logic signed [ErrBits-1:0] err_t;
  typedef logic signed [ErrBits:0]   err_wide_t;

  // endpoints closer than this on both axes need no walk
  localparam coord_t NearLimit     = coord_t'(2);
  localparam feat_t  WallThreshRst = feat_t'(10);

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_REPLY = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_PROBE    = 2'd0,
    KIND_VERDICT  = 2'd1,
    KIND_IDLE_ERR = 2'd2
  } kind_e;

  typedef struct packed {
    action_e action;
    coord_t  from_row;
    coord_t  from_col;
    coord_t  to_row;
    coord_t  to_col;
    feat_t   cell_feature;
  } req_t;

  typedef struct packed {
    kind_e  kind;
    coord_t probe_row;
    coord_t probe_col;
    logic   visible;
  } res_t;

  typedef struct packed {
    logic active;
  } walk_st_t;

endpackage

`default_nettype wire

// ===== sv/blw_req_if.sv =====
// ----------------------------------------------------------------------------
// blw_req_if
// Request channel: start items and probe replies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface blw_req_if;
  import blw_pkg::*;

  logic    valid;
  logic    ready;
  action_e action;
  coord_t  from_row;
  coord_t  from_col;
  coord_t  to_row;
  coord_t  to_col;
  feat_t   cell_feature;

  modport source (
    output valid, action, from_row, from_col, to_row, to_col, cell_feature,
    input  ready
  );

  modport sink (
    input  valid, action, from_row, from_col, to_row, to_col, cell_feature,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/blw_res_if.sv =====
// ----------------------------------------------------------------------------
// blw_res_if
// Result channel: probe requests, verdicts and idle errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface blw_res_if;
  import blw_pkg::*;

  logic   valid;
  logic   ready;
  kind_e  kind;
  coord_t probe_row;
  coord_t probe_col;
  logic   visible;

  modport source (
    output valid, kind, probe_row, probe_col, visible,
    input  ready
  );

  modport sink (
    input  valid, kind, probe_row, probe_col, visible,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/blw_in_reg.sv =====
// ----------------------------------------------------------------------------
// blw_in_reg
// Input register: captures one request transfer and holds it until the
// walk stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blw_in_reg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  blw_req_if.sink           req_i,
  input  wire logic         take_i,
  output logic              item_valid_o,
  output blw_pkg::req_t     item_o
);
  import blw_pkg::*;

  logic valid_q, valid_d;
  req_t item_q;
  logic load;

  assign req_i.ready = !valid_q || take_i;
  assign load        = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.action       <= req_i.action;
      item_q.from_row     <= req_i.from_row;
      item_q.from_col     <= req_i.from_col;
      item_q.to_row       <= req_i.to_row;
      item_q.to_col       <= req_i.to_col;
      item_q.cell_feature <= req_i.cell_feature;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== sv/blw_walk.sv =====
// ----------------------------------------------------------------------------
// blw_walk
// Walk state and one Bresenham step per item: start set-up, wall check,
// step and arrival test, giving the result for that item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blw_walk (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire blw_pkg::req_t  req_i,
  input  wire blw_pkg::feat_t wall_thr_i,
  output blw_pkg::res_t       res_o,
  output blw_pkg::walk_st_t   st_o
);
  import blw_pkg::*;

  logic   active_q, active_d;
  coord_t cur_row_q, cur_row_d, cur_col_q, cur_col_d;
  coord_t goal_row_q, goal_row_d, goal_col_q, goal_col_d;
  coord_t span_r_q, span_r_d, span_c_q, span_c_d;
  logic   rd_q, rd_d, cd_q, cd_d;
  err_t   err_q, err_d;

  // start set-up
  logic   start;
  logic   s_rd, s_cd, s_near;
  coord_t s_span_r, s_span_c;
  err_t   s_err;

  // step operands: fresh on start, stored otherwise
  coord_t b_row, b_col, b_goal_row, b_goal_col, b_span_r, b_span_c;
  logic   b_rd, b_cd;
  err_t   b_err;

  err_wide_t e2, sr_w, sc_w, e_n;
  logic      step_row, step_col, arrived;
  coord_t    adv_row, adv_col;
  err_t      adv_err;

  assign start = req_i.action == ACT_START;

  always_comb begin
    s_cd     = !(req_i.from_col < req_i.to_col);
    s_rd     = !(req_i.from_row < req_i.to_row);
    s_span_c = s_cd ? req_i.from_col - req_i.to_col : req_i.to_col - req_i.from_col;
    s_span_r = s_rd ? req_i.from_row - req_i.to_row : req_i.to_row - req_i.from_row;
    s_near   = (s_span_c < NearLimit) && (s_span_r < NearLimit);
    if (s_span_c > s_span_r) begin
      s_err = err_t'({1'b0, s_span_c >> 1});
    end else begin
      s_err = -err_t'({1'b0, s_span_r >> 1});
    end
  end

  assign b_row      = start ? req_i.from_row : cur_row_q;
  assign b_col      = start ? req_i.from_col : cur_col_q;
  assign b_goal_row = start ? req_i.to_row   : goal_row_q;
  assign b_goal_col = start ? req_i.to_col   : goal_col_q;
  assign b_span_r   = start ? s_span_r       : span_r_q;
  assign b_span_c   = start ? s_span_c       : span_c_q;
  assign b_rd       = start ? s_rd           : rd_q;
  assign b_cd       = start ? s_cd           : cd_q;
  assign b_err      = start ? s_err          : err_q;

  // one Bresenham step; the wide sum wraps harmlessly, the true value fits err_t
  always_comb begin
    e2       = {b_err[ErrBits-1], b_err};
    sr_w     = {2'b00, b_span_r};
    sc_w     = {2'b00, b_span_c};
    step_col = e2 > -sc_w;
    step_row = e2 < sr_w;
    e_n      = e2 - (step_col ? sr_w : '0) + (step_row ? sc_w : '0);
    adv_err  = e_n[ErrBits-1:0];
    adv_col  = b_col;
    adv_row  = b_row;
    if (step_col) begin
      adv_col = b_cd ? b_col - coord_t'(1) : b_col + coord_t'(1);
    end
    if (step_row) begin
      adv_row = b_rd ? b_row - coord_t'(1) : b_row + coord_t'(1);
    end
    arrived = (adv_col == b_goal_col) && (adv_row == b_goal_row);
  end

  always_comb begin
    active_d   = active_q;
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    goal_row_d = goal_row_q;
    goal_col_d = goal_col_q;
    span_r_d   = span_r_q;
    span_c_d   = span_c_q;
    rd_d       = rd_q;
    cd_d       = cd_q;
    err_d      = err_q;
    res_o      = '0;

    if (start || active_q) begin
      if (start) begin
        cur_row_d  = req_i.from_row;
        cur_col_d  = req_i.from_col;
        goal_row_d = req_i.to_row;
        goal_col_d = req_i.to_col;
        span_r_d   = s_span_r;
        span_c_d   = s_span_c;
        rd_d       = s_rd;
        cd_d       = s_cd;
      end
      priority if (start && s_near) begin
        active_d      = 1'b0;
        res_o.kind    = KIND_VERDICT;
        res_o.visible = 1'b1;
      end else if (!start && (req_i.cell_feature >= wall_thr_i)) begin
        active_d      = 1'b0;
        res_o.kind    = KIND_VERDICT;
        res_o.visible = 1'b0;
      end else begin
        err_d     = adv_err;
        cur_row_d = adv_row;
        cur_col_d = adv_col;
        if (arrived) begin
          active_d      = 1'b0;
          res_o.kind    = KIND_VERDICT;
          res_o.visible = 1'b1;
        end else begin
          active_d        = 1'b1;
          res_o.kind      = KIND_PROBE;
          res_o.probe_row = adv_row;
          res_o.probe_col = adv_col;
        end
      end
    end else begin
      res_o.kind = KIND_IDLE_ERR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      goal_row_q <= '0;
      goal_col_q <= '0;
      span_r_q   <= '0;
      span_c_q   <= '0;
      rd_q       <= 1'b0;
      cd_q       <= 1'b0;
      err_q      <= '0;
    end else if (step_i) begin
      active_q   <= active_d;
      cur_row_q  <= cur_row_d;
      cur_col_q  <= cur_col_d;
      goal_row_q <= goal_row_d;
      goal_col_q <= goal_col_d;
      span_r_q   <= span_r_d;
      span_c_q   <= span_c_d;
      rd_q       <= rd_d;
      cd_q       <= cd_d;
      err_q      <= err_d;
    end
  end

  assign st_o.active = active_q;

endmodule

`default_nettype wire

// ===== sv/bresenham_line_of_sight_walker.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_of_sight_walker
// Line-of-sight walker: Bresenham steps between two grid cells, one probe
// request, verdict or idle error per request item.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   req_i     in   valid/ready    action, from/to row/col, cell_feature
//   rsp_o     out  valid/ready    kind, probe_row, probe_col, visible
//   cfg       in   cfg_we_i       cfg_wdata_i -> wall threshold
//
// One item per cycle sustained while rsp_o is ready; a result passes through
// the input register, then the single step through blw_walk into the result
// register. Reset clears the walk state and both valid flags and sets the
// wall threshold to 10. A stalled result holds; one more request is still
// taken into the input register behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_of_sight_walker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  blw_req_if.sink              req_i,
  blw_res_if.source            rsp_o,
  input  wire logic            cfg_we_i,
  input  wire blw_pkg::feat_t  cfg_wdata_i
);
  import blw_pkg::*;

  feat_t    wall_thr_q;
  logic     item_valid;
  req_t     item;
  logic     advance;
  res_t     res_d, res_q;
  logic     out_valid_q, out_valid_d;
  walk_st_t walk_st;

  assign advance = item_valid && (!out_valid_q || rsp_o.ready);

  blw_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .take_i       (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  blw_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .req_i      (item),
    .wall_thr_i (wall_thr_q),
    .res_o      (res_d),
    .st_o       (walk_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_thr_q <= WallThreshRst;
    end else if (cfg_we_i) begin
      wall_thr_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.kind      = res_q.kind;
  assign rsp_o.probe_row = res_q.probe_row;
  assign rsp_o.probe_col = res_q.probe_col;
  assign rsp_o.visible   = res_q.visible;

`ifndef SYNTHESIS
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("step taken but no result registered");

  a_no_step_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !advance)
    else $error("result overwritten while stalled");

  a_idle_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !walk_st.active && item.action == ACT_REPLY)
      |=> (rsp_o.kind == KIND_IDLE_ERR))
    else $error("reply without a walk did not give an idle error");

  a_probe_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.kind != KIND_PROBE)
      |-> (rsp_o.probe_row == '0 && rsp_o.probe_col == '0))
    else $error("probe coordinates set on a non-probe result");
`endif

endmodule

`default_nettype wire
